FILE: rtl/core/hms_pkg.sv
// ----------------------------------------------------------------------------
// hms_pkg: shared types and constants for the HTML markup stripper
// Parse mode codes, match strings for markup openers and closers, the case
// fold helper and the result record passed from the parser to the top level.
// ----------------------------------------------------------------------------
package hms_pkg;

  localparam int unsigned NUM_PREFIX = 4;
  localparam int unsigned STR_DEPTH  = 16;

  typedef logic [7:0] byte_t;
  typedef logic [3:0] prog_t;
  typedef logic [1:0] which_t;

  // Parse modes, one-hot
  typedef enum logic [6:0] {
    MODE_TEXT     = 7'b0000001,
    MODE_PREFIX   = 7'b0000010,
    MODE_TAG      = 7'b0000100,
    MODE_COMMENT  = 7'b0001000,
    MODE_SCRIPT   = 7'b0010000,
    MODE_STYLE    = 7'b0100000,
    MODE_NOSCRIPT = 7'b1000000
  } mode_e;

  // Construct index, also the bit order of the live-prefix mask
  localparam which_t WHICH_COMMENT  = 2'd0;
  localparam which_t WHICH_SCRIPT   = 2'd1;
  localparam which_t WHICH_STYLE    = 2'd2;
  localparam which_t WHICH_NOSCRIPT = 2'd3;

  localparam byte_t CHAR_LT   = 8'h3C;
  localparam byte_t CHAR_GT   = 8'h3E;
  localparam byte_t CHAR_DASH = 8'h2D;
  localparam byte_t CHAR_UC_A = 8'h41;
  localparam byte_t CHAR_UC_Z = 8'h5A;
  localparam byte_t CASE_GAP  = 8'h20;

  // Openers, lower case, zero padded
  localparam byte_t PREFIX_STR [NUM_PREFIX][STR_DEPTH] = '{
    '{0: "<", 1: "!", 2: "-", 3: "-", default: 8'h00},
    '{0: "<", 1: "s", 2: "c", 3: "r", 4: "i", 5: "p", 6: "t", default: 8'h00},
    '{0: "<", 1: "s", 2: "t", 3: "y", 4: "l", 5: "e", default: 8'h00},
    '{0: "<", 1: "n", 2: "o", 3: "s", 4: "c", 5: "r", 6: "i", 7: "p", 8: "t",
      default: 8'h00}
  };
  localparam prog_t PREFIX_LEN [NUM_PREFIX] = '{4'd4, 4'd7, 4'd6, 4'd9};

  // Closers, lower case, zero padded
  localparam byte_t CLOSER_STR [NUM_PREFIX][STR_DEPTH] = '{
    '{0: "-", 1: "-", 2: ">", default: 8'h00},
    '{0: "<", 1: "/", 2: "s", 3: "c", 4: "r", 5: "i", 6: "p", 7: "t", 8: ">",
      default: 8'h00},
    '{0: "<", 1: "/", 2: "s", 3: "t", 4: "y", 5: "l", 6: "e", 7: ">",
      default: 8'h00},
    '{0: "<", 1: "/", 2: "n", 3: "o", 4: "s", 5: "c", 6: "r", 7: "i", 8: "p",
      9: "t", 10: ">", default: 8'h00}
  };
  localparam prog_t CLOSER_LEN [NUM_PREFIX] = '{4'd3, 4'd9, 4'd8, 4'd11};

  // Result record from the parser
  typedef struct packed {
    logic  emit;
    byte_t text_byte;
    logic  byte_valid;
    logic  doc_end;
  } res_t;

  // Fold ASCII upper case letters only
  function automatic byte_t fold_case(byte_t b);
    byte_t r;
    r = b;
    if (b >= CHAR_UC_A && b <= CHAR_UC_Z) begin
      r = b + CASE_GAP;
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/hms_if.sv
// ----------------------------------------------------------------------------
// hms_if: item channels of the HTML markup stripper
// Valid/ready channels for document bytes in and kept text bytes out.
// ----------------------------------------------------------------------------
interface hms_in_if;
  logic            valid;
  logic            ready;
  hms_pkg::byte_t  data_byte;
  logic            doc_last;

  modport source (output valid, output data_byte, output doc_last, input ready);
  modport sink   (input valid, input data_byte, input doc_last, output ready);
endinterface

interface hms_out_if;
  logic            valid;
  logic            ready;
  hms_pkg::byte_t  text_byte;
  logic            byte_valid;
  logic            doc_end;

  modport source (output valid, output text_byte, output byte_valid, output doc_end,
                  input ready);
  modport sink   (input valid, input text_byte, input byte_valid, input doc_end,
                  output ready);
endinterface

FILE: rtl/core/html_markup_stripper.sv
// ----------------------------------------------------------------------------
// html_markup_stripper: streaming filter that keeps text outside HTML markup
// Drops tags, comments and script/style/noscript blocks from a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries one document byte per item with doc_last on the final byte.
//   out_o carries kept text bytes; the item caused by the final byte has
//   doc_end set (byte_valid tells whether it also carries a kept byte).
//   Dropped bytes give no output item.
// Timing:
//   An accepted byte lands in the input register and is parsed from there;
//   its result enters the result register when that register can advance.
//   One byte per cycle is sustained while out_o takes items; the parse
//   state update is combinational compare logic ahead of the state registers.
// Reset:
//   rst_ni clears both item valid flags and puts the parser in text mode.
// Stall:
//   While out_o is held off, the result register keeps its item and the
//   input register still takes one more byte; after that in_i.ready drops
//   until out_o drains. Dropped bytes also wait behind a held result.
// ----------------------------------------------------------------------------
module html_markup_stripper (
  input  logic  clk_i,
  input  logic  rst_ni,
  hms_in_if.sink    in_i,
  hms_out_if.source out_o
);
  import hms_pkg::*;

  logic  in_valid_q;
  byte_t in_byte_q;
  logic  in_last_q;
  logic  out_valid_q;
  byte_t out_byte_q;
  logic  out_bvalid_q;
  logic  out_end_q;
  logic  advance;
  logic  step;
  res_t  res;

  // Pipeline control
  assign advance    = !out_valid_q || out_o.ready;
  assign step       = in_valid_q && advance;
  assign in_i.ready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.data_byte;
      in_last_q <= in_i.doc_last;
    end
  end

  hms_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_byte_i (in_byte_q),
    .doc_last_i  (in_last_q),
    .res_o       (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && res.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_byte_q   <= res.text_byte;
      out_bvalid_q <= res.byte_valid;
      out_end_q    <= res.doc_end;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.text_byte  = out_byte_q;
  assign out_o.byte_valid = out_bvalid_q;
  assign out_o.doc_end    = out_end_q;

  // Checks
  a_out_meaningful: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_bvalid_q || out_end_q))
    else $error("result item with neither text nor end of document");

  a_text_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_bvalid_q) |-> (out_byte_q == '0))
    else $error("dropped byte leaked into result");

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with empty result register");

  a_step_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && in_last_q) |=> out_valid_q && out_end_q)
    else $error("last byte gave no end of document item");

endmodule

FILE: rtl/core/hms_parser.sv
// ----------------------------------------------------------------------------
// hms_parser: markup parse state and per-byte decision
// Holds mode, match progress and the live-prefix mask; for each stepped byte
// decides whether it is kept text and advances the opener/closer matchers.
// ----------------------------------------------------------------------------
module hms_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  hms_pkg::byte_t data_byte_i,
  input  logic           doc_last_i,
  output hms_pkg::res_t  res_o
);
  import hms_pkg::*;

  mode_e                 mode_q, mode_d;
  prog_t                 prog_q, prog_d;
  logic [NUM_PREFIX-1:0] alive_q, alive_d;

  byte_t                 lc;
  logic [NUM_PREFIX-1:0] hit;
  logic                  done_any;
  which_t                done_idx;
  which_t                which;
  prog_t                 prog_inc;
  prog_t                 cprog;
  prog_t                 cnext;
  logic                  keep;

  assign lc       = fold_case(data_byte_i);
  assign prog_inc = prog_q + 4'd1;

  // Opener compare, all four in parallel
  always_comb begin
    hit      = '0;
    done_any = 1'b0;
    done_idx = WHICH_COMMENT;
    for (int k = 0; k < NUM_PREFIX; k++) begin
      hit[k] = alive_q[k] && (prog_q < PREFIX_LEN[k]) && (PREFIX_STR[k][prog_q] == lc);
      if (hit[k] && (prog_inc == PREFIX_LEN[k])) begin
        done_any = 1'b1;
        done_idx = which_t'(k);
      end
    end
  end

  // Which closer the current block mode waits for
  always_comb begin
    case (mode_q)
      MODE_SCRIPT:   which = WHICH_SCRIPT;
      MODE_STYLE:    which = WHICH_STYLE;
      MODE_NOSCRIPT: which = WHICH_NOSCRIPT;
      default:       which = WHICH_COMMENT;
    endcase
  end

  // Closer advance with overlap handling
  always_comb begin
    cprog = (prog_q >= CLOSER_LEN[which]) ? 4'd0 : prog_q;
    if (CLOSER_STR[which][cprog] == lc) begin
      cnext = cprog + 4'd1;
    end else if (which == WHICH_COMMENT) begin
      // extra dashes keep "--" matched
      if (lc == CHAR_DASH) begin
        cnext = (cprog == 4'd2) ? 4'd2 : 4'd1;
      end else begin
        cnext = 4'd0;
      end
    end else begin
      cnext = (lc == CHAR_LT) ? 4'd1 : 4'd0;
    end
  end

  // Next state
  always_comb begin
    mode_d  = mode_q;
    prog_d  = prog_q;
    alive_d = alive_q;
    keep    = 1'b0;
    case (mode_q)
      MODE_PREFIX: begin
        prog_d  = prog_inc;
        alive_d = hit;
        if (done_any) begin
          prog_d  = '0;
          alive_d = '0;
          case (done_idx)
            WHICH_SCRIPT:   mode_d = MODE_SCRIPT;
            WHICH_STYLE:    mode_d = MODE_STYLE;
            WHICH_NOSCRIPT: mode_d = MODE_NOSCRIPT;
            default:        mode_d = MODE_COMMENT;
          endcase
        end else if (hit == '0) begin
          mode_d = (data_byte_i == CHAR_GT) ? MODE_TEXT : MODE_TAG;
          prog_d = '0;
        end
      end
      MODE_TAG: begin
        if (data_byte_i == CHAR_GT) begin
          mode_d = MODE_TEXT;
        end
      end
      MODE_COMMENT, MODE_SCRIPT, MODE_STYLE, MODE_NOSCRIPT: begin
        if (cnext >= CLOSER_LEN[which]) begin
          mode_d = MODE_TEXT;
          prog_d = '0;
        end else begin
          prog_d = cnext;
        end
      end
      default: begin
        if (data_byte_i == CHAR_LT) begin
          mode_d  = MODE_PREFIX;
          prog_d  = 4'd1;
          alive_d = '1;
        end else begin
          keep = 1'b1;
        end
      end
    endcase
    // end of document returns everything to text mode
    if (doc_last_i) begin
      mode_d  = MODE_TEXT;
      prog_d  = '0;
      alive_d = '0;
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_TEXT;
      prog_q  <= '0;
      alive_q <= '0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      prog_q  <= prog_d;
      alive_q <= alive_d;
    end
  end

  // Result record
  assign res_o.emit       = keep || doc_last_i;
  assign res_o.text_byte  = keep ? data_byte_i : '0;
  assign res_o.byte_valid = keep;
  assign res_o.doc_end    = doc_last_i;

endmodule

FILE: tb/tb_html_markup_stripper.sv
// ----------------------------------------------------------------------------
// tb_html_markup_stripper: self-checking testbench for the markup stripper
// Feeds HTML documents one byte per item and predicts the kept text bytes
// and end-of-document marks with a behavioral parser of its own. Every item
// on the output channel is checked field by field against the oldest
// prediction. A few directed documents come first, then random documents
// built mostly from well-formed tags, comments and script/style/noscript
// blocks, with mixed case, closer fragments, truncation and raw noise.
// Both channels idle at random, with one long output hold-off.
// ----------------------------------------------------------------------------
module tb_html_markup_stripper;
  import hms_pkg::*;

  typedef struct packed {
    byte_t data;
    logic  last;
  } doc_byte_t;

  typedef struct packed {
    byte_t text_byte;
    logic  byte_valid;
    logic  doc_end;
  } kept_item_t;

  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned CALM_TAIL    = 150;
  localparam int unsigned HOLD_AT_ITEM = 400;
  localparam int unsigned HOLD_CYCLES  = 200;

  logic clk_i = 1'b0;
  logic rst_ni;

  hms_in_if  in_if ();
  hms_out_if out_if ();

  html_markup_stripper dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  doc_byte_t  byte_feed [$];
  kept_item_t kept_q [$];
  int         fail_count   = 0;
  int         accepted_cnt;
  int         send_gap;
  int         out_hold;
  int         long_hold;
  logic       long_hold_done;
  logic       calm;

  string opener_txt [NUM_PREFIX] = '{"<!--", "<script", "<style", "<noscript"};
  string closer_txt [NUM_PREFIX] = '{"-->", "</script>", "</style>", "</noscript>"};
  string tag_names [10] = '{"", "b", "p", "div", "/a", "!-", "scrip", "sty",
                            "noscrip", "!doctype html"};
  string body_chars = "-<>/!scriptylenoSCRIPT x";

  // --------------------------------------------------------------------------
  // Parser predictor
  // --------------------------------------------------------------------------
  mode_e                 pmode  = MODE_TEXT;
  prog_t                 pprog  = '0;
  logic [NUM_PREFIX-1:0] palive = '0;

  function automatic byte_t lower_ascii(byte_t b);
    if (b inside {["A":"Z"]}) return b | 8'h20;
    return b;
  endfunction

  // Next closer progress, overlaps included
  function automatic prog_t closer_next(which_t w, prog_t p, byte_t lc);
    prog_t q;
    q = (p >= CLOSER_LEN[w]) ? prog_t'(0) : p;
    if (CLOSER_STR[w][q] == lc) return q + 4'd1;
    // a run of dashes keeps "--" matched
    if (w == WHICH_COMMENT) begin
      if (lc != CHAR_DASH) return 4'd0;
      return (q == 4'd2) ? 4'd2 : 4'd1;
    end
    return (lc == CHAR_LT) ? 4'd1 : 4'd0;
  endfunction

  // Advances the parser by one byte; returns 1 when the byte causes an item
  function automatic bit strip_step(input byte_t b, input logic last,
                                    output kept_item_t r);
    byte_t                 lc;
    logic                  keep;
    logic [NUM_PREFIX-1:0] alive_n;
    bit                    hit;
    which_t                hit_w;
    which_t                w;
    prog_t                 np;
    int                    k;
    lc   = lower_ascii(b);
    keep = 1'b0;
    case (pmode)
      MODE_PREFIX: begin
        alive_n = '0;
        hit     = 1'b0;
        hit_w   = WHICH_COMMENT;
        for (k = 0; k < NUM_PREFIX; k++) begin
          if (palive[k] && pprog < PREFIX_LEN[k] && PREFIX_STR[k][pprog] == lc) begin
            alive_n[k] = 1'b1;
            if (pprog + 4'd1 == PREFIX_LEN[k]) begin
              hit   = 1'b1;
              hit_w = which_t'(k);
            end
          end
        end
        pprog  = pprog + 4'd1;
        palive = alive_n;
        if (hit) begin
          case (hit_w)
            WHICH_COMMENT: pmode = MODE_COMMENT;
            WHICH_SCRIPT:  pmode = MODE_SCRIPT;
            WHICH_STYLE:   pmode = MODE_STYLE;
            default:       pmode = MODE_NOSCRIPT;
          endcase
          pprog  = '0;
          palive = '0;
        end else if (alive_n == '0) begin
          // every opener failed: plain tag, and this byte belongs to it
          pmode = (b == CHAR_GT) ? MODE_TEXT : MODE_TAG;
          pprog = '0;
        end
      end
      MODE_TAG: begin
        if (b == CHAR_GT) pmode = MODE_TEXT;
      end
      MODE_COMMENT, MODE_SCRIPT, MODE_STYLE, MODE_NOSCRIPT: begin
        case (pmode)
          MODE_COMMENT: w = WHICH_COMMENT;
          MODE_SCRIPT:  w = WHICH_SCRIPT;
          MODE_STYLE:   w = WHICH_STYLE;
          default:      w = WHICH_NOSCRIPT;
        endcase
        np = closer_next(w, pprog, lc);
        if (np >= CLOSER_LEN[w]) begin
          pmode = MODE_TEXT;
          pprog = '0;
        end else begin
          pprog = np;
        end
      end
      default: begin
        if (b == CHAR_LT) begin
          pmode  = MODE_PREFIX;
          pprog  = 4'd1;
          palive = '1;
        end else begin
          keep = 1'b1;
        end
      end
    endcase
    // end of document always returns the parser to text mode
    if (last) begin
      pmode  = MODE_TEXT;
      pprog  = '0;
      palive = '0;
    end
    r.text_byte  = keep ? b : 8'h00;
    r.byte_valid = keep;
    r.doc_end    = last;
    return keep || last;
  endfunction

  // --------------------------------------------------------------------------
  // Document builders
  // --------------------------------------------------------------------------
  function automatic byte_t mix_case(byte_t c);
    if (c inside {["a":"z"]} && $urandom_range(1) == 1) return c & 8'hDF;
    return c;
  endfunction

  task automatic add_byte(byte_t b, logic last);
    doc_byte_t d;
    d.data = b;
    d.last = last;
    byte_feed = {byte_feed, d};
  endtask

  task automatic add_text(string s, bit mixed);
    int i;
    for (i = 0; i < s.len(); i++) begin
      add_byte(mixed ? mix_case(s[i]) : byte_t'(s[i]), 1'b0);
    end
  endtask

  task automatic mark_last();
    byte_feed[byte_feed.size() - 1].last = 1'b1;
  endtask

  task automatic add_doc(string s);
    add_text(s, 1'b0);
    mark_last();
  endtask

  // Block body: closer-like characters, closer fragments and raw bytes
  task automatic add_body(which_t w);
    int n;
    int i;
    string c;
    n = $urandom_range(16);
    for (i = 0; i < n; i++) begin
      case ($urandom_range(7))
        0: add_byte(byte_t'($urandom_range(255)), 1'b0);
        1: begin
          c = closer_txt[w];
          add_text(c.substr(0, $urandom_range(c.len() - 2)), 1'b1);
        end
        default: add_byte(mix_case(body_chars[$urandom_range(body_chars.len() - 1)]),
                          1'b0);
      endcase
    end
  endtask

  task automatic add_segment();
    int     n;
    int     i;
    byte_t  c;
    which_t w;
    case ($urandom_range(9))
      0, 1: begin
        // plain text, never opening a tag
        n = $urandom_range(1, 10);
        for (i = 0; i < n; i++) begin
          c = ($urandom_range(3) == 0) ? byte_t'($urandom_range(255))
                                       : byte_t'($urandom_range("a", "z"));
          if (c == CHAR_LT) c = " ";
          add_byte(mix_case(c), 1'b0);
        end
      end
      2, 3: begin
        add_byte(CHAR_LT, 1'b0);
        add_text(tag_names[$urandom_range(9)], 1'b1);
        if ($urandom_range(1) == 1) add_text(" id=x", 1'b1);
        add_byte(CHAR_GT, 1'b0);
      end
      4: begin
        // raw noise over the whole byte range
        n = $urandom_range(1, 8);
        for (i = 0; i < n; i++) add_byte(byte_t'($urandom_range(255)), 1'b0);
      end
      default: begin
        w = which_t'($urandom_range(NUM_PREFIX - 1));
        add_text(opener_txt[w], 1'b1);
        add_body(w);
        add_text(closer_txt[w], 1'b1);
      end
    endcase
  endtask

  task automatic add_document();
    int     n;
    int     i;
    which_t w;
    n = $urandom_range(1, 8);
    for (i = 0; i < n; i++) add_segment();
    // broken document: opener left open at the end
    if ($urandom_range(5) == 0) begin
      w = which_t'($urandom_range(NUM_PREFIX - 1));
      add_text(opener_txt[w].substr(0, $urandom_range(opener_txt[w].len() - 1)), 1'b1);
      if ($urandom_range(1) == 1) add_body(w);
    end
    mark_last();
  endtask

  // --------------------------------------------------------------------------
  // Input driver and prediction on acceptance
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : in_driver
    doc_byte_t  nxt;
    kept_item_t res;
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.data_byte <= 8'h00;
      in_if.doc_last  <= 1'b0;
      send_gap        <= 0;
      accepted_cnt    <= 0;
      calm            <= 1'b0;
      pmode            = MODE_TEXT;
      pprog            = '0;
      palive           = '0;
    end else begin
      calm <= (byte_feed.size() < CALM_TAIL);
      if (in_if.valid && in_if.ready) begin
        accepted_cnt <= accepted_cnt + 1;
        if (strip_step(in_if.data_byte, in_if.doc_last, res)) kept_q = {kept_q, res};
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_gap != 0) begin
          send_gap    <= send_gap - 1;
          in_if.valid <= 1'b0;
        end else if (byte_feed.size() != 0) begin
          nxt              = byte_feed.pop_front();
          in_if.valid     <= 1'b1;
          in_if.data_byte <= nxt.data;
          in_if.doc_last  <= nxt.last;
          // keep offering during the long hold-off so the block backs up
          if (!calm && long_hold == 0 && $urandom_range(9) == 0) begin
            send_gap <= $urandom_range(19, 1);
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Long output hold-off, once, in the middle of the run
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_hold      <= 0;
      long_hold_done <= 1'b0;
    end else if (!long_hold_done && accepted_cnt >= HOLD_AT_ITEM) begin
      long_hold      <= HOLD_CYCLES;
      long_hold_done <= 1'b1;
    end else if (long_hold != 0) begin
      long_hold <= long_hold - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor: checks each item and drives ready
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : out_monitor
    kept_item_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      out_hold     <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (kept_q.size() == 0) begin
          $error("unexpected item: text_byte %02h byte_valid %0b doc_end %0b",
                 out_if.text_byte, out_if.byte_valid, out_if.doc_end);
          fail_count++;
        end else begin
          want = kept_q.pop_front();
          if (out_if.text_byte !== want.text_byte) begin
            $error("text_byte: expected %02h, got %02h", want.text_byte, out_if.text_byte);
            fail_count++;
          end
          if (out_if.byte_valid !== want.byte_valid) begin
            $error("byte_valid: expected %0b, got %0b", want.byte_valid, out_if.byte_valid);
            fail_count++;
          end
          if (out_if.doc_end !== want.doc_end) begin
            $error("doc_end: expected %0b, got %0b", want.doc_end, out_if.doc_end);
            fail_count++;
          end
        end
      end
      if (long_hold != 0) begin
        out_if.ready <= 1'b0;
      end else if (out_hold != 0) begin
        out_hold     <= out_hold - 1;
        out_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(9) == 0) begin
        out_hold     <= $urandom_range(18);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    rst_ni = 1'b0;

    // byte extremes, empty tag, last byte kept
    add_byte(8'h00, 1'b0);
    add_text("A<>", 1'b0);
    add_byte(8'hFF, 1'b1);
    // comment closed after a run of dashes
    add_doc("<!--a--->z");
    // unterminated tag, and a document ending on its opening '<'
    add_doc("<x");
    add_doc("<");
    // near miss on an opener falls back to a plain tag
    add_doc("<sCr>q");

    while (byte_feed.size() < RANDOM_ITEMS + 24) add_document();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (byte_feed.size() != 0 || in_if.valid) @(posedge clk_i);
    while (kept_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #1000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
